>>> rtl/cursor_sequence_store_macros.svh
// Assertion macros for the cursor sequence store RTL, included by css_ctrl.
`ifndef CURSOR_SEQUENCE_STORE_MACROS_SVH
`define CURSOR_SEQUENCE_STORE_MACROS_SVH

// Checks that a condition holds at every rising clock edge outside reset.
`define CSS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Checks that a consequent holds whenever an antecedent holds.
`define CSS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/css_pkg.sv
// Shared constants, types and codes of the cursor sequence store.
`default_nettype none

package css_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ACT_START   = 3'd0,
    ACT_ADVANCE = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_ATTACH  = 3'd3,
    ACT_REMOVE  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  // Broadcast to every cell for one request.
  typedef struct packed {
    logic             place_en;
    logic             remove_en;
    logic [IDX_W-1:0] pos;
  } css_step_t;

endpackage

`default_nettype wire

>>> rtl/css_cell.sv
// One storage cell of the sequence: holds, loads the entry, or shifts from a neighbor.
`default_nettype none

module css_cell import css_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic [IDX_W-1:0]      idx_i,
  input  wire css_step_t             step_i,
  input  wire logic [DATA_WIDTH-1:0] entry_i,
  input  wire logic [DATA_WIDTH-1:0] from_lo_i,
  input  wire logic [DATA_WIDTH-1:0] from_hi_i,
  output logic      [DATA_WIDTH-1:0] value_o
);

  logic [DATA_WIDTH-1:0] value_q;
  logic [DATA_WIDTH-1:0] value_d;

  always_comb begin
    value_d = value_q;
    if (step_i.place_en) begin
      // Cells above the gap move up by one; the gap takes the new entry.
      if (idx_i == step_i.pos) begin
        value_d = entry_i;
      end else if (idx_i > step_i.pos) begin
        value_d = from_lo_i;
      end
    end else if (step_i.remove_en && (idx_i >= step_i.pos)) begin
      value_d = from_hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

>>> rtl/css_ctrl.sv
// Cursor and count control: decodes a request into cell steps and the result status.
`default_nettype none

`include "cursor_sequence_store_macros.svh"

module css_ctrl import css_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_i,
  input  wire logic [2:0]       action_i,
  output css_step_t             step_o,
  output logic      [CNT_W-1:0] count_o,
  output logic      [CNT_W-1:0] cursor_o,
  output status_e               status_o,
  output logic                  done_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cursor_q, cursor_d;
  status_e          status_q, status_d;
  logic             done_q;
  logic             has_cur;
  logic             full;
  logic [CNT_W-1:0] ins_pos;
  logic [CNT_W-1:0] att_pos;

  assign has_cur = cursor_q < count_q;
  assign full    = count_q >= CNT_W'(CAPACITY);
  assign ins_pos = has_cur ? cursor_q : '0;
  assign att_pos = has_cur ? (cursor_q + CNT_W'(1)) : count_q;

  always_comb begin
    count_d          = count_q;
    cursor_d         = cursor_q;
    status_d         = status_q;
    step_o.place_en  = 1'b0;
    step_o.remove_en = 1'b0;
    step_o.pos       = cursor_q[IDX_W-1:0];
    if (req_i) begin
      status_d = ST_OK;
      case (action_e'(action_i))
        ACT_START: begin
          cursor_d = '0;
        end
        ACT_ADVANCE: begin
          if (has_cur) begin
            cursor_d = cursor_q + CNT_W'(1);
          end else begin
            status_d = ST_NONE;
          end
        end
        ACT_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            step_o.place_en = 1'b1;
            step_o.pos      = ins_pos[IDX_W-1:0];
            count_d         = count_q + CNT_W'(1);
            cursor_d        = ins_pos;
          end
        end
        ACT_ATTACH: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            step_o.place_en = 1'b1;
            step_o.pos      = att_pos[IDX_W-1:0];
            count_d         = count_q + CNT_W'(1);
            cursor_d        = att_pos;
          end
        end
        ACT_REMOVE: begin
          // The item after the removed one slides into the cursor position.
          if (has_cur) begin
            step_o.remove_en = 1'b1;
            count_d          = count_q - CNT_W'(1);
          end else begin
            status_d = ST_NONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
      status_q <= ST_OK;
      done_q   <= 1'b0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
      status_q <= status_d;
      done_q   <= req_i;
    end
  end

  assign count_o  = count_q;
  assign cursor_o = cursor_q;
  assign status_o = status_q;
  assign done_o   = done_q;

  `CSS_ASSERT_ALWAYS(a_cursor_in_range, cursor_q <= count_q, "cursor beyond item count")
  `CSS_ASSERT_ALWAYS(a_count_in_range, count_q <= CNT_W'(CAPACITY), "item count above capacity")
  `CSS_ASSERT_IMPLY(a_done_after_req, done_q, $past(req_i), "result without a request")
  `CSS_ASSERT_IMPLY(a_refused_keeps_count, done_q && (status_q != ST_OK),
                    count_q == $past(count_q), "refused request changed the count")

endmodule

`default_nettype wire

>>> rtl/cursor_sequence_store.sv
// Top level of the cursor sequence store: a chain of storage cells plus cursor control.
// The result of a request appears on done_o, registered, in the cycle after it is accepted.
// Throughput: one request per cycle; busy is never raised, all cells update together.
// The result reads the cell at the cursor through one selector over the cell chain.
// Reset clears item count, cursor, status, done; cell contents stay undefined until written.
`default_nettype none

module cursor_sequence_store import css_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  action_i,
  input  wire logic [31:0] entry_value_i,
  output logic             done_o,
  output logic [31:0]      current_value_o,
  output logic             has_current_o,
  output logic [4:0]       item_count_o,
  output logic [1:0]       status_o
);

  logic                  req;
  css_step_t             step;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      cursor;
  status_e               status;
  logic                  has_cur;
  logic [DATA_WIDTH-1:0] cell_value [CAPACITY];

  assign busy = 1'b0;
  assign req  = start && !busy;

  css_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .action_i (action_i),
    .step_o   (step),
    .count_o  (count),
    .cursor_o (cursor),
    .status_o (status),
    .done_o   (done_o)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] from_lo;
    logic [DATA_WIDTH-1:0] from_hi;

    if (g == 0) begin : g_first
      assign from_lo = entry_value_i;
    end else begin : g_mid_lo
      assign from_lo = cell_value[g-1];
    end

    // The last cell has no upper neighbor and keeps its own value on a shift down.
    if (g == CAPACITY - 1) begin : g_last
      assign from_hi = cell_value[g];
    end else begin : g_mid_hi
      assign from_hi = cell_value[g+1];
    end

    css_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (IDX_W'(g)),
      .step_i    (step),
      .entry_i   (entry_value_i),
      .from_lo_i (from_lo),
      .from_hi_i (from_hi),
      .value_o   (cell_value[g])
    );
  end

  assign has_cur         = cursor < count;
  assign current_value_o = has_cur ? cell_value[cursor[IDX_W-1:0]] : '0;
  assign has_current_o   = has_cur;
  assign item_count_o    = count;
  assign status_o        = status;

endmodule

`default_nettype wire
